/* hw/rtl/xkbr_pkg.sv */
package xkbr_pkg;

  localparam int KEY_BYTES_DEF   = 16;
  localparam int CHUNK_BYTES_DEF = 64;

  localparam int BYTE_W      = 8;
  localparam int KEY_REG_W   = 64;
  localparam int KEY_LEN_W   = 5;
  localparam int CHUNK_LEN_W = 7;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_SLOTS   = 16;
  localparam int KEY_IDX_W   = 4;
  localparam int COUNT_W     = 5;

  localparam logic [KEY_LEN_W-1:0]   KEY_LEN_RST   = KEY_LEN_W'(1);
  localparam logic [CHUNK_LEN_W-1:0] CHUNK_LEN_RST = CHUNK_LEN_W'(20);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KEY_LOW   = 2'd0,
    REG_KEY_HIGH  = 2'd1,
    REG_KEY_LEN   = 2'd2,
    REG_CHUNK_LEN = 2'd3
  } cfg_reg_t;

  // block close request from the fill side to the drain side
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } drain_cmd_t;

endpackage

/* hw/rtl/xkbr_ram.sv */
module xkbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/xkbr_fill.sv */
module xkbr_fill import xkbr_pkg::*; #(
  parameter int MAX_KEY_BYTES   = KEY_BYTES_DEF,
  parameter int MAX_CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [BYTE_W-1:0]      data_byte,
  input  logic                   final_byte,
  input  logic [KEY_REG_W-1:0]   key_low,
  input  logic [KEY_REG_W-1:0]   key_high,
  input  logic [KEY_LEN_W-1:0]   key_length,
  input  logic [CHUNK_LEN_W-1:0] chunk_length,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [BYTE_W-1:0]      ram_wdata,
  output drain_cmd_t             cmd
);

  localparam int FW = $clog2(MAX_KEY_BYTES + 1);
  localparam int CW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam logic [KEY_LEN_W-1:0]   KLEN_MAX = KEY_LEN_W'(MAX_KEY_BYTES);
  localparam logic [CHUNK_LEN_W-1:0] CLEN_MAX = CHUNK_LEN_W'(MAX_CHUNK_BYTES);

  logic [FW-1:0] fill;
  logic [CW-1:0] chunk_pos;
  logic [FW-1:0] fill_inc;
  logic [CW-1:0] pos_inc;
  logic [KEY_LEN_W-1:0]   klen;
  logic [CHUNK_LEN_W-1:0] clen;
  logic [BYTE_W-1:0] key_bytes [KEY_SLOTS];
  logic [KEY_IDX_W-1:0] key_idx;
  logic chunk_end;
  logic close;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS / 2; i++) begin
      key_bytes[i]                 = key_low[i*BYTE_W +: BYTE_W];
      key_bytes[i + KEY_SLOTS / 2] = key_high[i*BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    klen = key_length;
    if (klen == '0) klen = KEY_LEN_W'(1);
    if (klen > KLEN_MAX) klen = KLEN_MAX;
    clen = chunk_length;
    if (clen == '0) clen = CHUNK_LEN_W'(1);
    if (clen > CLEN_MAX) clen = CLEN_MAX;
  end

  assign fill_inc  = fill + FW'(1);
  assign pos_inc   = chunk_pos + CW'(1);
  assign chunk_end = (CHUNK_LEN_W'(pos_inc) >= clen) || final_byte;
  assign close     = (KEY_LEN_W'(fill_inc) >= klen) || chunk_end;
  assign key_idx   = KEY_IDX_W'(fill[AW-1:0]);

  assign ram_we    = accept;
  assign ram_waddr = fill[AW-1:0];
  assign ram_wdata = data_byte ^ key_bytes[key_idx];

  assign cmd.start = accept && close;
  assign cmd.count = COUNT_W'(fill_inc);
  assign cmd.fin   = final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      chunk_pos <= '0;
    end else if (accept) begin
      fill      <= close ? '0 : fill_inc;
      chunk_pos <= chunk_end ? '0 : pos_inc;
    end
  end

endmodule

/* hw/rtl/xkbr_drain.sv */
module xkbr_drain import xkbr_pkg::*; #(
  parameter int MAX_KEY_BYTES = KEY_BYTES_DEF,
  parameter int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  drain_cmd_t        cmd,
  output logic              busy,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  logic [AW-1:0] rd_addr;
  logic          fin_blk;
  logic          rd_valid;
  logic          rd_last;
  logic          rd_fin;
  logic          move_out;
  logic          issue;
  logic [COUNT_W-1:0] top_idx;

  assign move_out  = rd_valid && (!m_tvalid || m_tready);
  assign issue     = busy && (!rd_valid || move_out);
  assign ram_re    = issue;
  assign ram_raddr = rd_addr;
  assign top_idx   = cmd.count - COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy    <= 1'b1;
        rd_addr <= top_idx[AW-1:0];
        fin_blk <= cmd.fin;
      end else if (issue) begin
        if (rd_addr == '0) begin
          busy <= 1'b0;
        end else begin
          rd_addr <= rd_addr - AW'(1);
        end
      end
      if (issue) begin
        rd_valid <= 1'b1;
        rd_last  <= (rd_addr == '0);
        rd_fin   <= (rd_addr == '0) && fin_blk;
      end else if (move_out) begin
        rd_valid <= 1'b0;
      end
      if (move_out) begin
        m_tvalid <= 1'b1;
        m_tdata  <= ram_rdata;
        m_tlast  <= rd_last;
        m_tuser  <= rd_fin;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && busy))
    else $error("block closed while previous block still draining");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy)
    else $error("drain did not start");

  a_last_read_done: assert property (@(posedge clk) disable iff (rst)
    issue && (rd_addr == '0) |=> !busy)
    else $error("drain kept running after last read");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !move_out |=> rd_valid)
    else $error("pending read data lost");

endmodule

/* hw/rtl/xor_key_block_reverse_decrypt_core.sv */
// xor key block reverse decryptor
// input stream: one ciphertext byte per request on s_tdata, s_tlast marks the
// last byte of the stream. output stream: one plain byte per request on
// m_tdata, m_tlast marks the last byte of a block, m_tuser the last byte of
// the stream.
// each byte is xored with the key byte at its place in the block and written
// to a 16-entry block ram. when a block closes (full, chunk end or stream end)
// s_tready drops and the block is read back from the ram in reverse order,
// one byte per cycle while the receiver takes them.
// the request that closes a block sets busy; the first output byte then passes
// through the ram read register and the output register. a block is filled
// and then drained from the single block ram; no byte is taken while it drains.
// when m_tready is low the read pipeline and output register hold, and the
// drain pauses; no request is lost.
// reset (rst, synchronous) clears the block and chunk counters and loads the
// register defaults: key zero, key length 1, chunk length 20. the ram needs
// no clearing. configuration writes (cfg_we, cfg_addr, cfg_data) take effect
// at once and are meant to happen while the block is idle.
module xor_key_block_reverse_decrypt_core import xkbr_pkg::*; #(
  parameter int MAX_KEY_BYTES   = KEY_BYTES_DEF,
  parameter int MAX_CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // data_byte
  input  logic                  s_tlast,   // final_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,   // plain_byte
  output logic                  m_tlast,   // block_last
  output logic                  m_tuser    // stream_last
);

  localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [KEY_REG_W-1:0]   key_low;
  logic [KEY_REG_W-1:0]   key_high;
  logic [KEY_LEN_W-1:0]   key_length;
  logic [CHUNK_LEN_W-1:0] chunk_length;

  logic              accept;
  logic              busy;
  drain_cmd_t        cmd;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= '0;
      key_high     <= '0;
      key_length   <= KEY_LEN_RST;
      chunk_length <= CHUNK_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_KEY_LOW:   key_low      <= cfg_data;
        REG_KEY_HIGH:  key_high     <= cfg_data;
        REG_KEY_LEN:   key_length   <= cfg_data[KEY_LEN_W-1:0];
        REG_CHUNK_LEN: chunk_length <= cfg_data[CHUNK_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  xkbr_fill #(
    .MAX_KEY_BYTES  (MAX_KEY_BYTES),
    .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES),
    .AW             (AW)
  ) u_fill (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .final_byte  (s_tlast),
    .key_low     (key_low),
    .key_high    (key_high),
    .key_length  (key_length),
    .chunk_length(chunk_length),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .cmd         (cmd)
  );

  xkbr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_KEY_BYTES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  xkbr_drain #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .AW           (AW)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .busy     (busy),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* tb/sv/tb_xor_key_block_reverse_decrypt_core.sv */
module tb_xor_key_block_reverse_decrypt_core import xkbr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT         = 46;
  localparam int BOTH_PCT         = 21;
  localparam int SETTLE_CYCLES    = 8;
  localparam int ITEMS_PER_CONFIG = 42;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] plain;
    logic              blk_last;
    logic              strm_last;
  } plain_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  // shadow registers and block state
  logic [KEY_REG_W-1:0]   key_low_r   = '0;
  logic [KEY_REG_W-1:0]   key_high_r  = '0;
  logic [KEY_LEN_W-1:0]   key_len_r   = KEY_LEN_RST;
  logic [CHUNK_LEN_W-1:0] chunk_len_r = CHUNK_LEN_RST;
  logic [BYTE_W-1:0]      blk_buf [KEY_SLOTS];
  int unsigned            blk_fill    = 0;
  int unsigned            chunk_pos   = 0;

  plain_rec_t plain_q[$];
  plain_rec_t want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent         = 0;
  int n_streams      = 0;
  int n_plain        = 0;
  int n_blocks       = 0;
  int n_writes       = 0;
  int n_errors       = 0;
  int cycle_count    = 0;

  xor_key_block_reverse_decrypt_core dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d plain bytes still pending", $time, plain_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // xor one cipher byte into the open block, queue the reversed block on close
  function automatic void decrypt_byte(input logic [BYTE_W-1:0] cipher, input logic fin);
    int unsigned klen;
    int unsigned clen;
    int unsigned slot;
    int unsigned count;
    logic        chunk_end;
    plain_rec_t  rec;
    klen = (key_len_r == 0) ? 1 : ((key_len_r > KEY_BYTES_DEF) ? KEY_BYTES_DEF : key_len_r);
    clen = (chunk_len_r == 0) ? 1 :
           ((chunk_len_r > CHUNK_BYTES_DEF) ? CHUNK_BYTES_DEF : chunk_len_r);
    slot = blk_fill & 15;
    blk_buf[slot] = cipher ^ BYTE_W'({key_high_r, key_low_r} >> (8 * slot));
    blk_fill = slot + 1;
    chunk_pos = (chunk_pos & 8'h7f) + 1;
    chunk_end = (chunk_pos >= clen) || fin;
    if (!(blk_fill >= klen || chunk_end)) return;
    count = blk_fill;
    for (int k = 0; k < count; k++) begin
      rec.plain     = blk_buf[(count - 1 - k) & 15];
      rec.blk_last  = (k == count - 1);
      rec.strm_last = (k == count - 1) && fin;
      plain_q.push_back(rec);
    end
    blk_fill = 0;
    if (chunk_end) chunk_pos = 0;
  endfunction

  // output side: random stalls and compare with the oldest expected byte
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_plain++;
        if (m_tlast) n_blocks++;
        if (plain_q.size() == 0) begin
          $display("%0t: unexpected plain byte %h last %b stream_last %b",
                   $time, m_tdata, m_tlast, m_tuser);
          n_errors++;
        end else begin
          want = plain_q.pop_front();
          if (m_tdata !== want.plain) begin
            $display("%0t: plain_byte expected %h got %h", $time, want.plain, m_tdata);
            n_errors++;
          end
          if (m_tlast !== want.blk_last) begin
            $display("%0t: block_last expected %b got %b", $time, want.blk_last, m_tlast);
            n_errors++;
          end
          if (m_tuser !== want.strm_last) begin
            $display("%0t: stream_last expected %b got %b", $time, want.strm_last, m_tuser);
            n_errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_req(input logic [BYTE_W-1:0] cipher, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cipher;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decrypt_byte(cipher, fin);
    n_sent++;
    if (fin) n_streams++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_LOW:   key_low_r = val;
      REG_KEY_HIGH:  key_high_r = val;
      REG_KEY_LEN:   key_len_r = val[KEY_LEN_W-1:0];
      REG_CHUNK_LEN: chunk_len_r = val[CHUNK_LEN_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // key zero, one byte blocks, stream end on the third byte
  task automatic test_defaults();
    send_req(8'h00, 1'b0);
    send_req(8'hff, 1'b0);
    send_req(8'h5a, 1'b1);
  endtask

  // zero lengths behave as one
  task automatic test_zero_lengths();
    write_reg(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_KEY_LEN, '0);
    write_reg(REG_CHUNK_LEN, '0);
    send_req(8'hff, 1'b0);
    send_req(8'h00, 1'b0);
  endtask

  // oversized lengths saturate, a full 16 byte block
  task automatic test_saturated_lengths();
    write_reg(REG_KEY_LOW, 64'h0123_4567_89ab_cdef);
    write_reg(REG_KEY_HIGH, 64'hfedc_ba98_7654_3210);
    write_reg(REG_KEY_LEN, 64'd31);
    write_reg(REG_CHUNK_LEN, 64'd127);
    for (int i = 0; i < KEY_SLOTS; i++) send_req((i % 2) ? 8'hff : 8'h00, 1'b0);
  endtask

  // lengths lowered while a block or chunk is open
  task automatic test_lowered_lengths();
    write_reg(REG_KEY_LEN, 64'd8);
    write_reg(REG_CHUNK_LEN, 64'd64);
    for (int i = 0; i < 3; i++) send_req(8'($urandom), 1'b0);
    write_reg(REG_KEY_LEN, 64'd2);
    send_req(8'($urandom), 1'b0);
    write_reg(REG_KEY_LEN, 64'd16);
    write_reg(REG_CHUNK_LEN, 64'd40);
    send_req(8'($urandom), 1'b0);
    send_req(8'($urandom), 1'b0);
    write_reg(REG_CHUNK_LEN, 64'd1);
    send_req(8'($urandom), 1'b0);
    send_req(8'($urandom), 1'b1);
  endtask

  task automatic test_random_phase(input int send_pct, input int stall_pct, input int corner,
                                   input bit pause_midway);
    logic [CFG_DATA_W-1:0]  val;
    logic [KEY_LEN_W-1:0]   klen;
    logic [CHUNK_LEN_W-1:0] clen;
    logic [BYTE_W-1:0]      cipher;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < 3; s++) begin
      if (s == 0) begin
        case (corner)
          0:       begin klen = 5'd16; clen = 7'd64;  end
          1:       begin klen = 5'd1;  clen = 7'd1;   end
          2:       begin klen = 5'd31; clen = 7'd127; end
          default: begin klen = 5'd0;  clen = 7'd0;   end
        endcase
      end else begin
        klen = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
        clen = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 24));
      end
      write_reg(REG_KEY_LOW, {$urandom, $urandom});
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      val = {$urandom, $urandom};
      val[KEY_LEN_W-1:0] = klen;
      write_reg(REG_KEY_LEN, val);
      val = {$urandom, $urandom};
      val[CHUNK_LEN_W-1:0] = clen;
      write_reg(REG_CHUNK_LEN, val);
      for (int i = 0; i < ITEMS_PER_CONFIG; i++) begin
        case ($urandom_range(7))
          0:       cipher = 8'h00;
          1:       cipher = 8'hff;
          default: cipher = 8'($urandom);
        endcase
        send_req(cipher, $urandom_range(19) == 0);
        if (pause_midway && s == 1 && i == ITEMS_PER_CONFIG / 2) wait_idle();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_zero_lengths();
    test_saturated_lengths();
    test_lowered_lengths();
    test_random_phase(0, 0, 0, 1'b0);
    test_random_phase(IDLE_PCT, 0, 1, 1'b1);
    test_random_phase(0, IDLE_PCT, 2, 1'b0);
    test_random_phase(BOTH_PCT, BOTH_PCT, 3, 1'b1);
    wait_idle();
    $display("run covered %0d cipher bytes in %0d streams and %0d register writes",
             n_sent, n_streams, n_writes);
    $display("checked %0d plain bytes in %0d blocks, %0d mismatches",
             n_plain, n_blocks, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/xkbr_pkg.sv
hw/rtl/xkbr_ram.sv
hw/rtl/xkbr_fill.sv
hw/rtl/xkbr_drain.sv
hw/rtl/xor_key_block_reverse_decrypt_core.sv
tb/sv/tb_xor_key_block_reverse_decrypt_core.sv
